>>> src/isqrt_pkg.sv
// ---------------------------------------------------------------------------
// isqrt_pkg: shared types for the integer square root block
// Holds the controller state type and the command and status bundles that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package isqrt_pkg;

  // Width of the root result port.
  localparam int ROOT_WIDTH = 32;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } isqrt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture a new radicand and clear the recurrence
    logic step;      // settle one root bit
    logic load_out;  // copy the finished root into the output register
  } isqrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_step; // the current step settles the least significant bit
  } isqrt_status_t;

endpackage

>>> src/isqrt_ctrl.sv
// ---------------------------------------------------------------------------
// isqrt_ctrl: controller for the integer square root block
// Sequences capture, the bit-by-bit recurrence and the hand-off of the
// result to the output register, and owns both channel handshakes.
// ---------------------------------------------------------------------------
module isqrt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  isqrt_pkg::isqrt_status_t status,
  output isqrt_pkg::isqrt_cmd_t    cmd
);
  import isqrt_pkg::*;

  isqrt_state_t state_r;
  isqrt_state_t state_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         in_ready;
  logic         out_free;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The output register can take a result when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            state_nxt   = ST_RUN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid is set on a load and cleared once the transaction completes.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = !in_ready;
  assign out_valid = out_valid_r;

endmodule

>>> src/isqrt_dp.sv
// ---------------------------------------------------------------------------
// isqrt_dp: datapath for the integer square root block
// Restoring digit-by-digit recurrence: each step brings down two radicand
// bits, subtracts the trial value 4*root+1 when it fits and shifts one root
// bit in. Also holds the step counter and the output register.
// ---------------------------------------------------------------------------
module isqrt_dp #(
  parameter int INPUT_WIDTH = 63
) (
  input  logic                                clk,
  input  logic [INPUT_WIDTH-1:0]              in_radicand,
  input  isqrt_pkg::isqrt_cmd_t               cmd,
  output isqrt_pkg::isqrt_status_t            status,
  output logic [isqrt_pkg::ROOT_WIDTH-1:0]    out_root
);
  import isqrt_pkg::*;

  localparam int STEPS = (INPUT_WIDTH + 1) / 2;
  localparam int RAD_W = 2 * STEPS;
  localparam int REM_W = STEPS + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [RAD_W-1:0]      rad_r;
  logic [RAD_W-1:0]      rad_nxt;
  logic [REM_W-1:0]      rem_r;
  logic [REM_W-1:0]      rem_nxt;
  logic [STEPS-1:0]      root_r;
  logic [STEPS-1:0]      root_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [ROOT_WIDTH-1:0] out_root_r;
  logic [SH_W-1:0]       rem_sh;
  logic [SH_W-1:0]       trial;
  logic [SH_W:0]         diff;
  logic                  fits;

  // One step of the recurrence.
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = SH_W'({root_r, 2'b01});
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign fits   = !diff[SH_W];

  // Next values of the working registers.
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    if (cmd.load_in) begin
      rad_nxt  = RAD_W'(in_radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(STEPS - 1);
    end else if (cmd.step) begin
      rad_nxt  = rad_r << 2;
      rem_nxt  = fits ? REM_W'(diff) : REM_W'(rem_sh);
      root_nxt = STEPS'({root_r, fits});
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  // Working registers; pure payload, no reset needed.
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  // Output register, loaded with the finished root.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_root_r <= ROOT_WIDTH'(root_r);
    end
  end

  assign status.last_step = (cnt_r == '0);
  assign out_root         = out_root_r;

endmodule

>>> src/integer_square_root.sv
// ---------------------------------------------------------------------------
// integer_square_root: floor square root of an unsigned integer
// Controller plus datapath computing one root bit per cycle.
// ---------------------------------------------------------------------------
//  Channel  Ports                            Direction  Content
//  in       in_valid, in_stall, in_radicand  input      radicand, INPUT_WIDTH bits
//  out      out_valid, out_stall, out_root   output     floor root, 32 bits
//
// An item passes through the shared recurrence step, one root bit at a time,
// and then through a hand-off to the output register.
// The next item is taken in the cycle the finished root moves to the output
// register; no new item is taken while one is still in the recurrence.
// A stalled output holds its result; the following item finishes its steps
// and then waits until the output register is free.
// Synchronous active-low reset returns the controller to idle and empties
// the output; no clearing pass is needed.
// ---------------------------------------------------------------------------
module integer_square_root #(
  parameter int INPUT_WIDTH = 63
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [INPUT_WIDTH-1:0]           in_radicand,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [isqrt_pkg::ROOT_WIDTH-1:0] out_root
);
  import isqrt_pkg::*;

  isqrt_cmd_t    cmd;
  isqrt_status_t status;

  // Sequencing and handshakes.
  isqrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Recurrence and output register.
  isqrt_dp #(
    .INPUT_WIDTH (INPUT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .in_radicand (in_radicand),
    .cmd         (cmd),
    .status      (status),
    .out_root    (out_root)
  );

endmodule

>>> src/isqrt_checker.sv
// ---------------------------------------------------------------------------
// isqrt_checker: port-level checks for the integer square root block
// Watches the handshakes of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module isqrt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  // A pending result is not withdrawn while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // After a transaction is accepted the block is busy computing.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken again right after a transaction");

  // The output is empty in the cycle after a reset edge.
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // Output valid only drops after a completed transaction.
  a_drop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without being taken");

endmodule

bind integer_square_root isqrt_checker u_isqrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
